@@ hdl/sks_pkg.sv @@
// Shared types and constants of the sorted key range search block.
package sks_pkg;

    localparam int KEY_W   = 32;
    localparam int CFG_W   = 11;
    localparam int ENTRY_W = 10;
    localparam int OUT_W   = 11;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Sources of the table read address.
    localparam logic [2:0] ADDR_MID_CUR     = 3'd0;
    localparam logic [2:0] ADDR_MID_NEXT    = 3'd1;
    localparam logic [2:0] ADDR_LEFT_FIRST  = 3'd2;
    localparam logic [2:0] ADDR_LEFT_NEXT   = 3'd3;
    localparam logic [2:0] ADDR_RIGHT_FIRST = 3'd4;
    localparam logic [2:0] ADDR_RIGHT_NEXT  = 3'd5;

    typedef struct packed {
        logic       write;
        logic       start;
        logic       set_mid;
        logic       probe;
        logic       hit;
        logic       left_dec;
        logic       right_inc;
        logic       load_out;
        logic [2:0] addr_sel;
    } t_cmd;

    typedef struct packed {
        logic n_zero;
        logic hit;
        logic last;
        logic first_zero;
        logic first_ge2;
        logic end_lt_n;
        logic end_next_lt_n;
        logic out_free;
    } t_status;

endpackage

@@ hdl/sks_ram.sv @@
// Generic simple dual port RAM with registered read data.
module sks_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/sks_dp.sv @@
// Datapath: key table, probe bounds, run stretch counters and output register.
module sks_dp #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sks_pkg::t_cmd                    i_cmd,
    output sks_pkg::t_status                 o_status,
    input  logic [sks_pkg::ENTRY_W-1:0]      i_entry_index,
    input  logic signed [sks_pkg::KEY_W-1:0] i_search_key,
    input  logic                             i_cfg_we,
    input  logic [sks_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic                             i_out_stall,
    output logic                             o_out_valid,
    output logic                             o_found,
    output logic [sks_pkg::OUT_W-1:0]        o_first_index,
    output logic [sks_pkg::OUT_W-1:0]        o_end_index
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int NW = (CW > sks_pkg::CFG_W) ? CW : sks_pkg::CFG_W;
    localparam logic [CW:0] ONE_W = 1;

    logic [sks_pkg::CFG_W-1:0]        r_entries;
    logic signed [sks_pkg::KEY_W-1:0] r_key, n_key;
    logic [CW-1:0]                    r_n, n_n;
    logic [AW-1:0]                    r_lo, n_lo;
    logic [AW-1:0]                    r_hi, n_hi;
    logic [AW-1:0]                    r_mid, n_mid;
    logic [AW-1:0]                    r_first, n_first;
    logic [CW-1:0]                    r_end, n_end;
    logic                             r_found, n_found;
    logic                             r_out_valid, n_out_valid;
    logic                             r_out_found, n_out_found;
    logic [sks_pkg::OUT_W-1:0]        r_out_first, n_out_first;
    logic [sks_pkg::OUT_W-1:0]        r_out_end, n_out_end;

    logic [NW-1:0]                 cfg_ext;
    logic [NW-1:0]                 depth_ext;
    logic [CW-1:0]                 n_sat;
    logic [sks_pkg::KEY_W-1:0]     ram_q;
    logic                          match;
    logic                          key_less;
    logic [AW:0]                   sum_cur;
    logic [AW-1:0]                 mid_cur;
    logic [AW-1:0]                 probe_lo;
    logic [AW-1:0]                 probe_hi;
    logic [AW:0]                   sum_next;
    logic [AW-1:0]                 mid_next;
    logic [CW:0]                   end_inc;
    logic [AW-1:0]                 rd_addr;
    logic                          wr_ok;

    sks_ram #(
        .WIDTH (sks_pkg::KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write && wr_ok),
        .i_waddr (AW'(i_entry_index)),
        .i_wdata ($unsigned(i_search_key)),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    always_comb begin
        cfg_ext   = NW'(r_entries);
        depth_ext = NW'(TABLE_DEPTH);
        n_sat     = CW'((cfg_ext > depth_ext) ? depth_ext : cfg_ext);
        wr_ok     = 32'(i_entry_index) < 32'(TABLE_DEPTH);

        match    = (ram_q == $unsigned(r_key));
        key_less = (r_key < $signed(ram_q));

        sum_cur = {1'b0, r_lo} + {1'b0, r_hi};
        mid_cur = sum_cur[AW:1];

        // A miss keeps the probed position inside the range unless it is the low end.
        probe_lo = key_less ? r_lo : ((r_mid == r_lo) ? r_lo + AW'(1) : r_mid);
        probe_hi = key_less ? r_mid : r_hi;
        sum_next = {1'b0, probe_lo} + {1'b0, probe_hi};
        mid_next = sum_next[AW:1];

        end_inc = {1'b0, r_end} + ONE_W;

        case (i_cmd.addr_sel)
            sks_pkg::ADDR_MID_CUR:     rd_addr = mid_cur;
            sks_pkg::ADDR_MID_NEXT:    rd_addr = mid_next;
            sks_pkg::ADDR_LEFT_FIRST:  rd_addr = r_first - AW'(1);
            sks_pkg::ADDR_LEFT_NEXT:   rd_addr = r_first - AW'(1) - AW'(1);
            sks_pkg::ADDR_RIGHT_FIRST: rd_addr = r_end[AW-1:0];
            sks_pkg::ADDR_RIGHT_NEXT:  rd_addr = end_inc[AW-1:0];
            default:                   rd_addr = mid_cur;
        endcase

        o_status.n_zero        = (n_sat == '0);
        o_status.hit           = match;
        o_status.last          = (r_lo == r_hi);
        o_status.first_zero    = (r_first == '0);
        o_status.first_ge2     = (r_first > AW'(1));
        o_status.end_lt_n      = (r_end < r_n);
        o_status.end_next_lt_n = (end_inc < {1'b0, r_n});
        o_status.out_free      = !r_out_valid || !i_out_stall;
    end

    always_comb begin
        n_key       = r_key;
        n_n         = r_n;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_first     = r_first;
        n_end       = r_end;
        n_found     = r_found;
        n_out_found = r_out_found;
        n_out_first = r_out_first;
        n_out_end   = r_out_end;
        n_out_valid = r_out_valid && i_out_stall;

        if (i_cmd.start) begin
            n_key   = i_search_key;
            n_n     = n_sat;
            n_lo    = '0;
            n_hi    = AW'(n_sat - CW'(1));
            n_found = 1'b0;
            n_first = '0;
            n_end   = '0;
        end
        if (i_cmd.set_mid) begin
            n_mid = mid_cur;
        end
        if (i_cmd.probe) begin
            n_lo  = probe_lo;
            n_hi  = probe_hi;
            n_mid = mid_next;
        end
        if (i_cmd.hit) begin
            n_found = 1'b1;
            n_first = r_mid;
            n_end   = CW'(r_mid) + CW'(1);
        end
        if (i_cmd.left_dec) begin
            n_first = r_first - AW'(1);
        end
        if (i_cmd.right_inc) begin
            n_end = end_inc[CW-1:0];
        end
        if (i_cmd.load_out) begin
            n_out_valid = 1'b1;
            n_out_found = r_found;
            n_out_first = sks_pkg::OUT_W'(r_first);
            n_out_end   = sks_pkg::OUT_W'(r_end);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_entries <= i_cfg_wdata;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_n         <= n_n;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_first     <= n_first;
        r_end       <= n_end;
        r_found     <= n_found;
        r_out_found <= n_out_found;
        r_out_first <= n_out_first;
        r_out_end   <= n_out_end;
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_out_found;
    assign o_first_index = r_out_first;
    assign o_end_index   = r_out_end;

    // A step that misses must leave a nonempty probe range behind.
    a_range_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.probe |=> (r_lo <= r_hi))
        else $error("probe range became empty after a step");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_first == '0 && r_out_end == '0))
        else $error("miss word carries nonzero indices");

    a_hit_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_found) |-> (r_out_end > r_out_first))
        else $error("hit word has an empty run");

endmodule

@@ hdl/sks_ctrl.sv @@
// Controller: issues table writes and sequences the probe and the two run stretches of a search.
module sks_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_op,
    output logic             o_in_stall,
    input  sks_pkg::t_status i_status,
    output sks_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_PROBE = 3'd2;
    localparam logic [2:0] S_LGO   = 3'd3;
    localparam logic [2:0] S_LEFT  = 3'd4;
    localparam logic [2:0] S_RGO   = 3'd5;
    localparam logic [2:0] S_RIGHT = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.addr_sel = sks_pkg::ADDR_MID_CUR;
        o_in_stall     = (r_state != S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_op == sks_pkg::OP_WRITE) begin
                        o_cmd.write = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state = i_status.n_zero ? S_DONE : S_START;
                    end
                end
            end
            S_START: begin
                o_cmd.set_mid  = 1'b1;
                o_cmd.addr_sel = sks_pkg::ADDR_MID_CUR;
                n_state        = S_PROBE;
            end
            S_PROBE: begin
                if (i_status.hit) begin
                    o_cmd.hit = 1'b1;
                    n_state   = S_LGO;
                end else if (i_status.last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.probe    = 1'b1;
                    o_cmd.addr_sel = sks_pkg::ADDR_MID_NEXT;
                end
            end
            S_LGO: begin
                if (i_status.first_zero) begin
                    n_state = S_RGO;
                end else begin
                    o_cmd.addr_sel = sks_pkg::ADDR_LEFT_FIRST;
                    n_state        = S_LEFT;
                end
            end
            S_LEFT: begin
                if (i_status.hit) begin
                    o_cmd.left_dec = 1'b1;
                    // The next read goes out now so the walk moves one entry per cycle.
                    if (i_status.first_ge2) begin
                        o_cmd.addr_sel = sks_pkg::ADDR_LEFT_NEXT;
                    end else begin
                        n_state = S_RGO;
                    end
                end else begin
                    n_state = S_RGO;
                end
            end
            S_RGO: begin
                if (i_status.end_lt_n) begin
                    o_cmd.addr_sel = sks_pkg::ADDR_RIGHT_FIRST;
                    n_state        = S_RIGHT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RIGHT: begin
                if (i_status.hit) begin
                    o_cmd.right_inc = 1'b1;
                    if (i_status.end_next_lt_n) begin
                        o_cmd.addr_sel = sks_pkg::ADDR_RIGHT_NEXT;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hdl/sorted_key_range_search.sv @@
// Equal range search over a sorted table of signed 32-bit keys.
//
// Input channel (i_in_valid / o_in_stall): a word with i_op = write stores
// i_search_key at i_entry_index; indices at or above TABLE_DEPTH are dropped.
// A word with i_op = search looks up i_search_key in the first entries_in_use
// positions (saturated at TABLE_DEPTH) and gives one output word.
// Configuration: i_cfg_we writes i_cfg_wdata to entries_in_use.
//
// A search first loads the key and bounds and sets the first probe position,
// then narrows the range by binary probes. A hit then starts and ends the
// two stretches, one step for each equal key found left and right of the
// hit. A final step loads the output register. Every probe and stretch step
// is one read of the single table read port.
//
// Output channel (o_out_valid / i_out_stall): found, first and end index.
// A miss gives found low and both indices zero. The output register holds a
// word until it is taken; the next word is accepted meanwhile, and a finished
// search waits for the register to free up. Reset clears entries_in_use and
// the handshakes; table contents are undefined until written.
module sorted_key_range_search #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_op,
    input  logic [sks_pkg::ENTRY_W-1:0]      i_entry_index,
    input  logic signed [sks_pkg::KEY_W-1:0] i_search_key,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_found,
    output logic [sks_pkg::OUT_W-1:0]        o_first_index,
    output logic [sks_pkg::OUT_W-1:0]        o_end_index,
    input  logic                             i_cfg_we,
    input  logic [sks_pkg::CFG_W-1:0]        i_cfg_wdata
);

    sks_pkg::t_cmd    cmd;
    sks_pkg::t_status status;

    sks_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sks_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_entry_index (i_entry_index),
        .i_search_key  (i_search_key),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_found       (o_found),
        .o_first_index (o_first_index),
        .o_end_index   (o_end_index)
    );

endmodule
